### rtl/mvt_pkg.sv
// Package for the 4x4 matrix-vector transform engine.
// Holds widths, command codes, saturation limits and the pipeline control struct.
// No dependencies.
package mvt_pkg;

  // Field and arithmetic widths.
  localparam int DATA_W  = 32;
  localparam int NUM_DIM = 4;
  localparam int IDX_W   = $clog2(NUM_DIM);
  localparam int PROD_W  = 2 * DATA_W;
  localparam int SUM_W   = PROD_W + IDX_W;

  // Default number of fraction bits of the Q format.
  localparam int FRAC_BITS_DEF = 16;

  // Saturation limits of a result, sign extended to the sum width.
  localparam logic signed [SUM_W-1:0] RES_MAX =
    {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] RES_MIN =
    {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  // Command codes of an input item.
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_XFORM = 1'b1
  } cmd_e;

  // Per-stage load enables handed to the row units.
  typedef struct packed {
    logic en_mul;
    logic en_sum;
    logic en_out;
  } pipe_ctrl_t;

endpackage

### rtl/mvt_intf.sv
// Channel interfaces of the transform engine: input items and result items.
// Each carries valid, ready and the payload fields. Depends on mvt_pkg.
interface mvt_in_if import mvt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         col;
  logic signed [DATA_W-1:0] elem_value;
  logic signed [DATA_W-1:0] vec_x;
  logic signed [DATA_W-1:0] vec_y;
  logic signed [DATA_W-1:0] vec_z;
  logic signed [DATA_W-1:0] vec_w;
  logic                     three_mode;

  modport source (
    output valid, cmd, row, col, elem_value, vec_x, vec_y, vec_z, vec_w, three_mode,
    input  ready
  );
  modport sink (
    input  valid, cmd, row, col, elem_value, vec_x, vec_y, vec_z, vec_w, three_mode,
    output ready
  );
endinterface

interface mvt_out_if import mvt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_0;
  logic signed [DATA_W-1:0] out_1;
  logic signed [DATA_W-1:0] out_2;
  logic signed [DATA_W-1:0] out_3;
  logic                     overflow;

  modport source (
    output valid, out_0, out_1, out_2, out_3, overflow,
    input  ready
  );
  modport sink (
    input  valid, out_0, out_1, out_2, out_3, overflow,
    output ready
  );
endinterface

### rtl/mvt_row_unit.sv
// One matrix row of the transform: four products, their sum, then the
// floor shift and saturation to 32 bits. Depends on mvt_pkg.
module mvt_row_unit import mvt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  pipe_ctrl_t               ctrl_i,
  input  logic signed [DATA_W-1:0] coef_i [NUM_DIM],
  input  logic signed [DATA_W-1:0] vec_i  [NUM_DIM],
  output logic signed [DATA_W-1:0] res_o,
  output logic                     sat_o
);

  logic signed [PROD_W-1:0] prod_d [NUM_DIM];
  logic signed [PROD_W-1:0] prod_q [NUM_DIM];
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SUM_W-1:0]  shifted;
  logic signed [DATA_W-1:0] res_d;
  logic signed [DATA_W-1:0] res_q;
  logic                     sat_d;
  logic                     sat_q;

  // Exact signed products, one multiplier per column.
  always_comb begin
    for (int c = 0; c < NUM_DIM; c++) begin
      prod_d[c] = PROD_W'(coef_i[c]) * PROD_W'(vec_i[c]);
    end
  end

  // Exact sum of the four products, with headroom for the carries.
  always_comb begin
    sum_d = '0;
    for (int c = 0; c < NUM_DIM; c++) begin
      sum_d = sum_d + SUM_W'(prod_q[c]);
    end
  end

  // The arithmetic shift rounds towards minus infinity; then clamp to 32 bits.
  always_comb begin
    shifted = sum_q >>> FRAC_BITS;
    sat_d   = 1'b0;
    res_d   = DATA_W'(shifted);
    if (shifted > RES_MAX) begin
      sat_d = 1'b1;
      res_d = DATA_W'(RES_MAX);
    end else if (shifted < RES_MIN) begin
      sat_d = 1'b1;
      res_d = DATA_W'(RES_MIN);
    end
  end

  // Pipeline registers; payload only, so no reset is needed.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_mul) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.en_sum) begin
      sum_q <= sum_d;
    end
    if (ctrl_i.en_out) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

### rtl/matrix_vector_transform_4x4.sv
// Matrix-vector transform engine, 4x4 matrix times vector in signed Q format.
// A transform item's result reaches out_o through the product, sum and output registers.
// Throughput: one item per cycle; the four-stage pipeline (input, product, sum,
// output register) only stalls when the output is held back. Loads give no result.
// Reset clears the matrix store to zero and empties the pipeline.
module matrix_vector_transform_4x4 import mvt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mvt_in_if.sink   in_i,
  mvt_out_if.source out_o
);

  // Matrix store, read at fixed places by the row units.
  logic signed [DATA_W-1:0] matrix_q [NUM_DIM][NUM_DIM];

  // Input stage.
  logic                     v0_q;
  logic                     cmd0_q;
  logic [IDX_W-1:0]         row0_q;
  logic [IDX_W-1:0]         col0_q;
  logic signed [DATA_W-1:0] elem0_q;
  logic signed [DATA_W-1:0] vec0_q [NUM_DIM];
  logic                     three0_q;

  // Valid and mode flags of the later stages.
  logic v1_q, v2_q, v3_q;
  logic three1_q, three2_q, three3_q;

  logic       ready_1, ready_2, ready_3;
  logic       adv0;
  logic       in_acc;
  logic       is_load0;
  pipe_ctrl_t ctrl;

  logic signed [DATA_W-1:0] row_res [NUM_DIM];
  logic                     row_sat [NUM_DIM];

  // Back-pressure chain: a stage may take new data when it is empty or moving on.
  assign ready_3  = !v3_q || out_o.ready;
  assign ready_2  = !v2_q || ready_3;
  assign ready_1  = !v1_q || ready_2;
  assign is_load0 = (cmd0_q == CMD_LOAD);
  assign adv0     = v0_q && (is_load0 || ready_1);
  assign in_i.ready = !v0_q || adv0;
  assign in_acc   = in_i.valid && in_i.ready;

  assign ctrl.en_mul = ready_1;
  assign ctrl.en_sum = ready_2;
  assign ctrl.en_out = ready_3;

  // Control registers of the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (in_acc) begin
        v0_q <= 1'b1;
      end else if (adv0) begin
        v0_q <= 1'b0;
      end
      if (ready_1) begin
        v1_q <= v0_q && !is_load0;
      end
      if (ready_2) begin
        v2_q <= v1_q;
      end
      if (ready_3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Input item register; in three mode the w component is forced to zero.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd0_q    <= in_i.cmd;
      row0_q    <= in_i.row;
      col0_q    <= in_i.col;
      elem0_q   <= in_i.elem_value;
      vec0_q[0] <= in_i.vec_x;
      vec0_q[1] <= in_i.vec_y;
      vec0_q[2] <= in_i.vec_z;
      vec0_q[3] <= in_i.three_mode ? '0 : in_i.vec_w;
      three0_q  <= in_i.three_mode;
    end
    if (ready_1) begin
      three1_q <= three0_q;
    end
    if (ready_2) begin
      three2_q <= three1_q;
    end
    if (ready_3) begin
      three3_q <= three2_q;
    end
  end

  // A load writes the store as it leaves the input stage, so that transforms
  // ahead of it have already taken their products and those behind see it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_DIM; r++) begin
        for (int c = 0; c < NUM_DIM; c++) begin
          matrix_q[r][c] <= '0;
        end
      end
    end else if (v0_q && is_load0) begin
      matrix_q[row0_q][col0_q] <= elem0_q;
    end
  end

  // One row unit per output component.
  for (genvar r = 0; r < NUM_DIM; r++) begin : g_row
    mvt_row_unit #(
      .FRAC_BITS (FRAC_BITS)
    ) u_row (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .coef_i (matrix_q[r]),
      .vec_i  (vec0_q),
      .res_o  (row_res[r]),
      .sat_o  (row_sat[r])
    );
  end

  // Result item; row 3 is dropped in three mode.
  assign out_o.valid    = v3_q;
  assign out_o.out_0    = row_res[0];
  assign out_o.out_1    = row_res[1];
  assign out_o.out_2    = row_res[2];
  assign out_o.out_3    = three3_q ? '0 : row_res[3];
  assign out_o.overflow = row_sat[0] || row_sat[1] || row_sat[2] ||
                          (row_sat[3] && !three3_q);

  // A load leaving the input stage never enters the product stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v0_q && is_load0 && ready_1) |=> !v1_q)
    else $error("load item entered the product stage");

  // A transform leaving the input stage always reaches the product stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v0_q && !is_load0 && ready_1) |=> v1_q)
    else $error("transform item lost at the product stage");

  // A load updates the addressed matrix entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v0_q && is_load0) |=> (matrix_q[$past(row0_q)][$past(col0_q)] == $past(elem0_q)))
    else $error("matrix entry not written by load");

  // Overflow is only flagged when some component sits at a limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.overflow) |->
      (out_o.out_0 == DATA_W'(RES_MAX) || out_o.out_0 == DATA_W'(RES_MIN) ||
       out_o.out_1 == DATA_W'(RES_MAX) || out_o.out_1 == DATA_W'(RES_MIN) ||
       out_o.out_2 == DATA_W'(RES_MAX) || out_o.out_2 == DATA_W'(RES_MIN) ||
       out_o.out_3 == DATA_W'(RES_MAX) || out_o.out_3 == DATA_W'(RES_MIN)))
    else $error("overflow flagged without a saturated component");

endmodule

### verif/matrix_vector_transform_4x4_tb.sv
// Testbench for the 4x4 matrix-vector transform engine: loads and transforms
// are driven under varied idling and back-pressure and checked against a predictor.
// Depends on mvt_pkg, mvt_in_if, mvt_out_if and matrix_vector_transform_4x4.
module matrix_vector_transform_4x4_tb;
  import mvt_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

  // One input item as the engine sees it.
  typedef struct packed {
    cmd_e                     cmd;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] elem_value;
    logic signed [DATA_W-1:0] vec_x;
    logic signed [DATA_W-1:0] vec_y;
    logic signed [DATA_W-1:0] vec_z;
    logic signed [DATA_W-1:0] vec_w;
    logic                     three_mode;
  } xform_item_t;

  // One transformed vertex.
  typedef struct packed {
    logic signed [DATA_W-1:0] out_0;
    logic signed [DATA_W-1:0] out_1;
    logic signed [DATA_W-1:0] out_2;
    logic signed [DATA_W-1:0] out_3;
    logic                     overflow;
  } xform_result_t;

  // Keeps a shadow copy of the matrix and the vertices still owed by the engine.
  class xform_scoreboard;
    logic signed [DATA_W-1:0] shadow_matrix [NUM_DIM*NUM_DIM];
    xform_result_t            vertex_q [$];
    int                       errors;

    function new();
      foreach (shadow_matrix[i]) shadow_matrix[i] = '0;
      errors = 0;
    endfunction

    // A load updates the shadow matrix; a transform queues the predicted vertex.
    function void note_item(xform_item_t it);
      logic signed [DATA_W-1:0] vec [NUM_DIM];
      logic signed [DATA_W-1:0] row_res [NUM_DIM];
      logic signed [SUM_W-1:0]  acc;
      longint                   prod;
      int                       dims;
      xform_result_t            res;
      if (it.cmd == CMD_LOAD) begin
        shadow_matrix[{it.row, it.col}] = it.elem_value;
        return;
      end
      vec[0] = it.vec_x;
      vec[1] = it.vec_y;
      vec[2] = it.vec_z;
      vec[3] = it.vec_w;
      dims = it.three_mode ? NUM_DIM - 1 : NUM_DIM;
      res.overflow = 1'b0;
      for (int r = 0; r < NUM_DIM; r++) begin
        row_res[r] = '0;
        if (r < dims) begin
          // Exact sum of the products, then a flooring shift and saturation.
          acc = '0;
          for (int c = 0; c < dims; c++) begin
            prod = longint'(shadow_matrix[r*NUM_DIM+c]) * longint'(vec[c]);
            acc  = acc + prod;
          end
          acc = acc >>> FRAC;
          if (acc > RES_MAX) begin
            row_res[r]   = Q_MAX;
            res.overflow = 1'b1;
          end else if (acc < RES_MIN) begin
            row_res[r]   = Q_MIN;
            res.overflow = 1'b1;
          end else begin
            row_res[r] = acc[DATA_W-1:0];
          end
        end
      end
      res.out_0 = row_res[0];
      res.out_1 = row_res[1];
      res.out_2 = row_res[2];
      res.out_3 = row_res[3];
      vertex_q.push_back(res);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compares an accepted vertex with the oldest prediction.
    function void check_result(xform_result_t got);
      xform_result_t want;
      if (vertex_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d ovf %0b",
                 $time, got.out_0, got.out_1, got.out_2, got.out_3, got.overflow);
        return;
      end
      want = vertex_q.pop_front();
      compare_field("out_0", want.out_0, got.out_0);
      compare_field("out_1", want.out_1, got.out_1);
      compare_field("out_2", want.out_2, got.out_2);
      compare_field("out_3", want.out_3, got.out_3);
      compare_field("overflow", want.overflow, got.overflow);
    endfunction

    function int pending();
      return vertex_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  mvt_in_if  in_ch ();
  mvt_out_if res_ch ();

  matrix_vector_transform_4x4 #(
    .FRAC_BITS (FRAC)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (res_ch)
  );

  xform_scoreboard board = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;

  always #6 clk_i = ~clk_i;

  // A fixed-point value drawn from magnitude classes so that both exact and
  // saturating sums are common.
  function automatic logic signed [DATA_W-1:0] rand_fixed();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(7))
      0, 1, 2: v = int'($urandom_range(0, 2097151)) - 1048576;
      3:       v = int'($urandom_range(0, 262143)) - 131072;
      4, 5:    v = $urandom;
      6: begin
        case ($urandom_range(5))
          0:       v = Q_MAX;
          1:       v = Q_MIN;
          2:       v = '0;
          3:       v = Q_ONE;
          4:       v = -Q_ONE;
          default: v = -1;
        endcase
      end
      default: begin
        v = 32'sd1 <<< $urandom_range(31);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // Unused fields of both item kinds carry random values.
  function automatic xform_item_t load_item(int r, int c, logic signed [DATA_W-1:0] v);
    xform_item_t it;
    it            = {$urandom, $urandom, $urandom, $urandom, $urandom, 6'($urandom)};
    it.cmd        = CMD_LOAD;
    it.row        = IDX_W'(r);
    it.col        = IDX_W'(c);
    it.elem_value = v;
    return it;
  endfunction

  function automatic xform_item_t xform_item(logic signed [DATA_W-1:0] x,
                                             logic signed [DATA_W-1:0] y,
                                             logic signed [DATA_W-1:0] z,
                                             logic signed [DATA_W-1:0] w,
                                             logic three);
    xform_item_t it;
    it            = {$urandom, $urandom, $urandom, $urandom, $urandom, 6'($urandom)};
    it.cmd        = CMD_XFORM;
    it.vec_x      = x;
    it.vec_y      = y;
    it.vec_z      = z;
    it.vec_w      = w;
    it.three_mode = three;
    return it;
  endfunction

  // Offers one item after random idle cycles and waits until it is taken.
  task automatic send_item(xform_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= it.cmd;
    in_ch.row        <= it.row;
    in_ch.col        <= it.col;
    in_ch.elem_value <= it.elem_value;
    in_ch.vec_x      <= it.vec_x;
    in_ch.vec_y      <= it.vec_y;
    in_ch.vec_z      <= it.vec_z;
    in_ch.vec_w      <= it.vec_w;
    in_ch.three_mode <= it.three_mode;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_item(it);
  endtask

  // Stops offering items and waits for every owed vertex, with a limit.
  task automatic drain_vertices();
    int guard;
    guard = 0;
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (board.pending() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  // Result side: random or long stalls, and a check of each accepted vertex.
  initial begin
    int hold_left;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready)
        board.check_result({res_ch.out_0, res_ch.out_1, res_ch.out_2, res_ch.out_3,
                            res_ch.overflow});
    end
  end

  // Main stimulus: reset, directed items, then random phases.
  initial begin
    xform_item_t it;
    int          phase_idle  [4];
    int          phase_stall [4];
    phase_idle       = '{0, 82, 0, 26};
    phase_stall      = '{0, 0, 82, 26};
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_LOAD;
    in_ch.row        = '0;
    in_ch.col        = '0;
    in_ch.elem_value = '0;
    in_ch.vec_x      = '0;
    in_ch.vec_y      = '0;
    in_ch.vec_z      = '0;
    in_ch.vec_w      = '0;
    in_ch.three_mode = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The store is clear after reset, so the first vertex is all zeros.
    send_item(xform_item(Q_MAX, Q_MIN, Q_ONE, -1, 1'b0));
    // Identity diagonal passes the vector through in both modes.
    for (int d = 0; d < NUM_DIM; d++) send_item(load_item(d, d, Q_ONE));
    send_item(xform_item(32'sh0001_8000, -32'sh0002_4000, Q_MAX, Q_MIN, 1'b0));
    send_item(xform_item(32'sh0001_8000, -32'sh0002_4000, Q_MAX, Q_MIN, 1'b1));
    // Extreme elements drive rows into positive and negative saturation.
    send_item(load_item(0, 1, Q_MAX));
    send_item(load_item(1, 0, Q_MIN));
    send_item(xform_item(Q_MAX, Q_MAX, '0, '0, 1'b0));
    // Row three saturates only in full mode; three mode ignores it and w.
    send_item(load_item(3, 3, Q_MIN));
    send_item(xform_item('0, '0, 32'sd5, Q_MIN, 1'b1));
    send_item(xform_item('0, '0, 32'sd5, Q_MIN, 1'b0));
    // A tiny negative product floors to minus one.
    send_item(load_item(2, 2, -1));
    send_item(xform_item('0, '0, 32'sd1, '0, 1'b1));
    // Corner addresses, then all-maximum and all-minimum vectors.
    send_item(load_item(3, 0, 32'sh1234_5678));
    send_item(load_item(0, 3, -32'sh0765_4321));
    send_item(xform_item(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0));
    send_item(xform_item(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0));

    for (int ph = 0; ph < 4; ph++) begin
      // The sender pauses until every owed vertex has come back.
      drain_vertices();
      send_idle_pct  = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      if (ph == 0 || ph == 3) hold_req = 64;
      repeat (225) begin
        if ($urandom_range(3) == 0)
          it = load_item($urandom_range(3), $urandom_range(3), rand_fixed());
        else
          it = xform_item(rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed(),
                          1'($urandom_range(1)));
        send_item(it);
      end
    end

    drain_vertices();
    repeat (8) @(posedge clk_i);
    if (board.pending() != 0) begin
      board.errors++;
      $display("%0t: %0d results expected but never arrived", $time, board.pending());
    end
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2400000;
    $display("status: fail");
    $finish;
  end

endmodule
